@@ src/tat_pkg.sv @@
// ----------------------------------------------------------------------------
// tat_pkg
// Shared widths, codes, operation set and row helpers for the triangle
// adjacency table.
// ----------------------------------------------------------------------------
package tat_pkg;

    localparam int MAX_TRIANGLES = 1024;
    localparam int MAX_VERTICES  = 4096;

    localparam int TRI_W  = $clog2(MAX_TRIANGLES);
    localparam int CNT_W  = TRI_W + 1;
    localparam int LINK_W = CNT_W;
    localparam int VERT_W = $clog2(MAX_VERTICES) + 1;

    localparam logic [1:0] CMD_APPEND  = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_CONNECT = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef logic [2:0][VERT_W-1:0] vert_row_t;
    typedef logic [2:0][LINK_W-1:0] link_row_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_CHECK,
        OP_APPEND,
        OP_RD_T,
        OP_CAP_NB,
        OP_RD_NB,
        OP_WR_UNLINK,
        OP_RD_LAST,
        OP_WR_COPY,
        OP_WR_RELINK,
        OP_NEXT_S,
        OP_RD_I,
        OP_CAP_I,
        OP_SET_J,
        OP_RD_J
    } op_t;

    typedef enum logic [2:0] {
        XOP_NONE,
        XOP_CMP_J,
        XOP_WR_LI,
        XOP_WR_LJ,
        XOP_NEXT_I,
        XOP_RESULT
    } xop_t;

    typedef struct packed {
        op_t  op;
        xop_t xop;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       idx_ok;
        logic       count_zero;
        logic       nb_valid;
        logic       s_last;
        logic       has_open_i;
        logic       hit;
        logic       i_tail;
        logic       j_tail;
    } dp_stat_t;

    function automatic logic has_open(input link_row_t row);
        return (row[0] == '0) || (row[1] == '0) || (row[2] == '0);
    endfunction

    function automatic logic [1:0] open_slot(input link_row_t row);
        logic [1:0] slot;
        if (row[2] == '0)
            slot = 2'd2;
        else if (row[1] == '0)
            slot = 2'd1;
        else
            slot = 2'd0;
        return slot;
    endfunction

    function automatic logic [1:0] next_slot(input logic [1:0] slot);
        return (slot == 2'd2) ? 2'd0 : slot + 2'd1;
    endfunction

endpackage

@@ src/tat_datapath.sv @@
// ----------------------------------------------------------------------------
// tat_datapath
// Triangle row memories, counters, input and result registers; carries out
// one operation per cycle as the controller directs.
// ----------------------------------------------------------------------------
module tat_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tat_pkg::dp_cmd_t             dcmd,
    output tat_pkg::dp_stat_t            dstat,
    input  logic [1:0]                   command,
    input  logic [tat_pkg::TRI_W-1:0]    tri_index,
    input  logic [tat_pkg::VERT_W-1:0]   vert_a,
    input  logic [tat_pkg::VERT_W-1:0]   vert_b,
    input  logic [tat_pkg::VERT_W-1:0]   vert_c,
    input  logic [tat_pkg::LINK_W-1:0]   link_a,
    input  logic [tat_pkg::LINK_W-1:0]   link_b,
    input  logic [tat_pkg::LINK_W-1:0]   link_c,
    output logic [1:0]                   status,
    output logic [tat_pkg::CNT_W-1:0]    count_now,
    output logic [tat_pkg::VERT_W-1:0]   out_vert_a,
    output logic [tat_pkg::VERT_W-1:0]   out_vert_b,
    output logic [tat_pkg::VERT_W-1:0]   out_vert_c,
    output logic [tat_pkg::LINK_W-1:0]   out_link_a,
    output logic [tat_pkg::LINK_W-1:0]   out_link_b,
    output logic [tat_pkg::LINK_W-1:0]   out_link_c
);

    localparam int TW = tat_pkg::TRI_W;
    localparam int CW = tat_pkg::CNT_W;

    tat_pkg::vert_row_t vmem [0:tat_pkg::MAX_TRIANGLES-1];
    tat_pkg::link_row_t lmem [0:tat_pkg::MAX_TRIANGLES-1];

    tat_pkg::vert_row_t vrd_reg;
    tat_pkg::link_row_t lrd_reg;

    logic [1:0]         cmd_reg;
    logic [TW-1:0]      idx_reg;
    tat_pkg::vert_row_t vin_reg;
    tat_pkg::link_row_t lin_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [1:0]         s_reg, s_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [CW-1:0]      nb_reg;
    tat_pkg::vert_row_t vi_reg;
    tat_pkg::link_row_t li_reg;
    logic [1:0]         sj_reg;
    logic [1:0]         status_reg;

    logic [1:0]               st_reg;
    logic [CW-1:0]            cnt_out_reg;
    tat_pkg::vert_row_t       vout_reg;
    tat_pkg::link_row_t       lout_reg;

    logic               rd_en;
    logic [TW-1:0]      rd_addr;
    logic               wr_v, wr_l;
    logic [TW-1:0]      wr_addr;
    logic [2:0]         wr_mask;
    tat_pkg::vert_row_t wv_row;
    tat_pkg::link_row_t wl_row;

    logic [CW-1:0]      t_plus;
    logic [CW-1:0]      nb_less;
    logic [CW-1:0]      last;
    logic [1:0]         si, ai, bi, aj, bj, sj;
    logic               hit;
    logic [CW-1:0]      from_val, to_val;
    logic [2:0]         match_mask;

    assign t_plus  = CW'(idx_reg) + CW'(1);
    assign nb_less = nb_reg - CW'(1);
    assign last    = count_reg - CW'(1);

    assign si = tat_pkg::open_slot(li_reg);
    assign ai = si;
    assign bi = tat_pkg::next_slot(si);
    assign sj = tat_pkg::open_slot(lrd_reg);
    assign aj = sj;
    assign bj = tat_pkg::next_slot(sj);
    assign hit = tat_pkg::has_open(lrd_reg)
                 && (vi_reg[ai] == vrd_reg[bj]) && (vi_reg[bi] == vrd_reg[aj]);

    always_comb
    begin
        if (dcmd.op == tat_pkg::OP_WR_UNLINK)
        begin
            from_val = t_plus;
            to_val   = '0;
        end
        else
        begin
            from_val = count_reg;
            to_val   = t_plus;
        end
        if (lrd_reg[0] == from_val)
            match_mask = 3'b001;
        else if (lrd_reg[1] == from_val)
            match_mask = 3'b010;
        else if (lrd_reg[2] == from_val)
            match_mask = 3'b100;
        else
            match_mask = 3'b000;
    end

    always_comb
    begin
        rd_en = 1'b1;
        unique case (dcmd.op)
            tat_pkg::OP_RD_T:    rd_addr = idx_reg;
            tat_pkg::OP_RD_NB:   rd_addr = nb_less[TW-1:0];
            tat_pkg::OP_RD_LAST: rd_addr = last[TW-1:0];
            tat_pkg::OP_RD_I:    rd_addr = i_reg[TW-1:0];
            tat_pkg::OP_RD_J:    rd_addr = j_reg[TW-1:0];
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = idx_reg;
            end
        endcase
    end

    always_comb
    begin
        wr_v    = 1'b0;
        wr_l    = 1'b0;
        wr_addr = idx_reg;
        wr_mask = 3'b000;
        wv_row  = vrd_reg;
        wl_row  = lrd_reg;
        unique case (dcmd.op)
            tat_pkg::OP_APPEND:
            begin
                wr_v    = 1'b1;
                wr_l    = 1'b1;
                wr_addr = count_reg[TW-1:0];
                wr_mask = 3'b111;
                wv_row  = vin_reg;
                wl_row  = lin_reg;
            end
            tat_pkg::OP_WR_UNLINK, tat_pkg::OP_WR_RELINK:
            begin
                wr_l    = 1'b1;
                wr_addr = nb_less[TW-1:0];
                wr_mask = match_mask;
                wl_row  = {3{to_val}};
            end
            tat_pkg::OP_WR_COPY:
            begin
                wr_v    = 1'b1;
                wr_l    = 1'b1;
                wr_mask = 3'b001 << s_reg;
            end
            default:
            begin
            end
        endcase
        unique case (dcmd.xop)
            tat_pkg::XOP_WR_LI:
            begin
                wr_l    = 1'b1;
                wr_addr = i_reg[TW-1:0];
                wr_mask = 3'b001 << si;
                wl_row  = {3{j_reg + CW'(1)}};
            end
            tat_pkg::XOP_WR_LJ:
            begin
                wr_l    = 1'b1;
                wr_addr = j_reg[TW-1:0];
                wr_mask = 3'b001 << sj_reg;
                wl_row  = {3{i_reg + CW'(1)}};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            vrd_reg <= vmem[rd_addr];
            lrd_reg <= lmem[rd_addr];
        end
        for (int k = 0; k < 3; k++)
        begin
            if (wr_v && wr_mask[k])
                vmem[wr_addr][k] <= wv_row[k];
            if (wr_l && wr_mask[k])
                lmem[wr_addr][k] <= wl_row[k];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        s_next     = s_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        unique case (dcmd.op)
            tat_pkg::OP_CHECK:
            begin
                s_next = 2'd0;
                i_next = '0;
            end
            tat_pkg::OP_APPEND: count_next = count_reg + CW'(1);
            tat_pkg::OP_NEXT_S:
            begin
                if (s_reg == 2'd2)
                    count_next = last;
                s_next = tat_pkg::next_slot(s_reg);
            end
            tat_pkg::OP_SET_J: j_next = i_reg + CW'(1);
            default:
            begin
            end
        endcase
        unique case (dcmd.xop)
            tat_pkg::XOP_CMP_J:
            begin
                if (!hit)
                    j_next = j_reg + CW'(1);
            end
            tat_pkg::XOP_NEXT_I: i_next = i_reg + CW'(1);
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        i_reg <= i_next;
        j_reg <= j_next;
        if (dcmd.op == tat_pkg::OP_LATCH)
        begin
            cmd_reg <= command;
            idx_reg <= tri_index;
            vin_reg <= {vert_c, vert_b, vert_a};
            lin_reg <= {link_c, link_b, link_a};
        end
        if (dcmd.op == tat_pkg::OP_CHECK)
        begin
            if (cmd_reg == tat_pkg::CMD_APPEND && count_reg >= CW'(tat_pkg::MAX_TRIANGLES))
                status_reg <= tat_pkg::ST_FULL;
            else if ((cmd_reg == tat_pkg::CMD_REMOVE || cmd_reg == tat_pkg::CMD_READ)
                     && CW'(idx_reg) >= count_reg)
                status_reg <= tat_pkg::ST_RANGE;
            else
                status_reg <= tat_pkg::ST_DONE;
        end
        if (dcmd.op == tat_pkg::OP_CAP_NB || dcmd.op == tat_pkg::OP_WR_COPY)
            nb_reg <= lrd_reg[s_reg];
        if (dcmd.op == tat_pkg::OP_CAP_I)
        begin
            vi_reg <= vrd_reg;
            li_reg <= lrd_reg;
        end
        if (dcmd.xop == tat_pkg::XOP_CMP_J)
            sj_reg <= sj;
        if (dcmd.xop == tat_pkg::XOP_RESULT)
        begin
            st_reg      <= status_reg;
            cnt_out_reg <= count_reg;
            if (cmd_reg == tat_pkg::CMD_READ && status_reg == tat_pkg::ST_DONE)
            begin
                vout_reg <= vrd_reg;
                lout_reg <= lrd_reg;
            end
            else
            begin
                vout_reg <= '0;
                lout_reg <= '0;
            end
        end
    end

    assign dstat.cmd        = cmd_reg;
    assign dstat.full       = count_reg >= CW'(tat_pkg::MAX_TRIANGLES);
    assign dstat.idx_ok     = CW'(idx_reg) < count_reg;
    assign dstat.count_zero = count_reg == '0;
    assign dstat.nb_valid   = (nb_reg != '0) && (nb_reg <= CW'(tat_pkg::MAX_TRIANGLES));
    assign dstat.s_last     = s_reg == 2'd2;
    assign dstat.has_open_i = tat_pkg::has_open(li_reg);
    assign dstat.hit        = hit;
    assign dstat.i_tail     = (i_reg + CW'(1)) >= count_reg;
    assign dstat.j_tail     = (j_reg + CW'(1)) >= count_reg;

    assign status     = st_reg;
    assign count_now  = cnt_out_reg;
    assign out_vert_a = vout_reg[0];
    assign out_vert_b = vout_reg[1];
    assign out_vert_c = vout_reg[2];
    assign out_link_a = lout_reg[0];
    assign out_link_b = lout_reg[1];
    assign out_link_c = lout_reg[2];

endmodule

@@ src/tat_controller.sv @@
// ----------------------------------------------------------------------------
// tat_controller
// Sequencer for append, remove, connect and read; owns the handshakes.
// ----------------------------------------------------------------------------
module tat_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tat_pkg::dp_stat_t   dstat,
    output tat_pkg::dp_cmd_t    dcmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECODE = 5'd1;
    localparam logic [4:0] S_APPEND = 5'd2;
    localparam logic [4:0] S_READ   = 5'd3;
    localparam logic [4:0] S_R0     = 5'd4;
    localparam logic [4:0] S_R1     = 5'd5;
    localparam logic [4:0] S_R2     = 5'd6;
    localparam logic [4:0] S_R3     = 5'd7;
    localparam logic [4:0] S_R4     = 5'd8;
    localparam logic [4:0] S_R5     = 5'd9;
    localparam logic [4:0] S_R6     = 5'd10;
    localparam logic [4:0] S_R7     = 5'd11;
    localparam logic [4:0] S_R8     = 5'd12;
    localparam logic [4:0] S_C1     = 5'd13;
    localparam logic [4:0] S_C2     = 5'd14;
    localparam logic [4:0] S_C3     = 5'd15;
    localparam logic [4:0] S_C4     = 5'd16;
    localparam logic [4:0] S_C5     = 5'd17;
    localparam logic [4:0] S_C6     = 5'd18;
    localparam logic [4:0] S_C7     = 5'd19;
    localparam logic [4:0] S_CNI    = 5'd20;
    localparam logic [4:0] S_FIN    = 5'd21;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       load;

    assign load = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        dcmd.op    = tat_pkg::OP_NOP;
        dcmd.xop   = tat_pkg::XOP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dcmd.op    = tat_pkg::OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                dcmd.op = tat_pkg::OP_CHECK;
                unique case (dstat.cmd)
                    tat_pkg::CMD_APPEND:  state_next = dstat.full ? S_FIN : S_APPEND;
                    tat_pkg::CMD_REMOVE:  state_next = dstat.idx_ok ? S_R0 : S_FIN;
                    tat_pkg::CMD_CONNECT: state_next = dstat.count_zero ? S_FIN : S_C1;
                    default:              state_next = dstat.idx_ok ? S_READ : S_FIN;
                endcase
            end
            S_APPEND:
            begin
                dcmd.op    = tat_pkg::OP_APPEND;
                state_next = S_FIN;
            end
            S_READ:
            begin
                dcmd.op    = tat_pkg::OP_RD_T;
                state_next = S_FIN;
            end
            S_R0:
            begin
                dcmd.op    = tat_pkg::OP_RD_T;
                state_next = S_R1;
            end
            S_R1:
            begin
                dcmd.op    = tat_pkg::OP_CAP_NB;
                state_next = S_R2;
            end
            S_R2:
            begin
                dcmd.op    = tat_pkg::OP_RD_NB;
                state_next = dstat.nb_valid ? S_R3 : S_R4;
            end
            S_R3:
            begin
                dcmd.op    = tat_pkg::OP_WR_UNLINK;
                state_next = S_R4;
            end
            S_R4:
            begin
                dcmd.op    = tat_pkg::OP_RD_LAST;
                state_next = S_R5;
            end
            S_R5:
            begin
                dcmd.op    = tat_pkg::OP_WR_COPY;
                state_next = S_R6;
            end
            S_R6:
            begin
                dcmd.op    = tat_pkg::OP_RD_NB;
                state_next = dstat.nb_valid ? S_R7 : S_R8;
            end
            S_R7:
            begin
                dcmd.op    = tat_pkg::OP_WR_RELINK;
                state_next = S_R8;
            end
            S_R8:
            begin
                dcmd.op    = tat_pkg::OP_NEXT_S;
                state_next = dstat.s_last ? S_FIN : S_R0;
            end
            S_C1:
            begin
                dcmd.op    = tat_pkg::OP_RD_I;
                state_next = S_C2;
            end
            S_C2:
            begin
                dcmd.op    = tat_pkg::OP_CAP_I;
                state_next = S_C3;
            end
            S_C3:
            begin
                dcmd.op    = tat_pkg::OP_SET_J;
                state_next = (!dstat.has_open_i || dstat.i_tail) ? S_CNI : S_C4;
            end
            S_C4:
            begin
                dcmd.op    = tat_pkg::OP_RD_J;
                state_next = S_C5;
            end
            S_C5:
            begin
                dcmd.xop = tat_pkg::XOP_CMP_J;
                if (dstat.hit)
                    state_next = S_C6;
                else if (dstat.j_tail)
                    state_next = S_CNI;
                else
                    state_next = S_C4;
            end
            S_C6:
            begin
                dcmd.xop   = tat_pkg::XOP_WR_LI;
                state_next = S_C7;
            end
            S_C7:
            begin
                dcmd.xop   = tat_pkg::XOP_WR_LJ;
                state_next = S_CNI;
            end
            S_CNI:
            begin
                dcmd.xop   = tat_pkg::XOP_NEXT_I;
                state_next = dstat.i_tail ? S_FIN : S_C1;
            end
            S_FIN:
            begin
                if (load)
                begin
                    dcmd.xop   = tat_pkg::XOP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

@@ src/triangle_adjacency_table.sv @@
// ----------------------------------------------------------------------------
// triangle_adjacency_table
// Triangle table with neighbor links: append, remove, connect, read.
//
//   channel | handshake          | payload
//   in      | in_valid/in_ready  | command, tri_index, vert_a..c, link_a..c
//   out     | out_valid/out_ready| status, count_now, out_vert_a..c, out_link_a..c
//
// One command at a time, one result per command; rows live in one
// single-port-read, single-port-write memory pair, so the sequencer sets the pace.
// Remove works through the 3 link slots in turn: it unlinks the removed row's
// neighbor, copies that slot of the last row into the freed row and relinks its
// neighbor; connect links each row with an open edge to the first later row sharing it.
// Reset clears the count and sequencer; table contents need no clearing.
// A stalled result holds the sequencer in its final step until taken.
// ----------------------------------------------------------------------------
module triangle_adjacency_table
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   command,
    input  logic [tat_pkg::TRI_W-1:0]    tri_index,
    input  logic [tat_pkg::VERT_W-1:0]   vert_a,
    input  logic [tat_pkg::VERT_W-1:0]   vert_b,
    input  logic [tat_pkg::VERT_W-1:0]   vert_c,
    input  logic [tat_pkg::LINK_W-1:0]   link_a,
    input  logic [tat_pkg::LINK_W-1:0]   link_b,
    input  logic [tat_pkg::LINK_W-1:0]   link_c,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [tat_pkg::CNT_W-1:0]    count_now,
    output logic [tat_pkg::VERT_W-1:0]   out_vert_a,
    output logic [tat_pkg::VERT_W-1:0]   out_vert_b,
    output logic [tat_pkg::VERT_W-1:0]   out_vert_c,
    output logic [tat_pkg::LINK_W-1:0]   out_link_a,
    output logic [tat_pkg::LINK_W-1:0]   out_link_b,
    output logic [tat_pkg::LINK_W-1:0]   out_link_c
);

    tat_pkg::dp_cmd_t  dcmd;
    tat_pkg::dp_stat_t dstat;

    tat_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dstat     (dstat),
        .dcmd      (dcmd)
    );

    tat_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .dcmd       (dcmd),
        .dstat      (dstat),
        .command    (command),
        .tri_index  (tri_index),
        .vert_a     (vert_a),
        .vert_b     (vert_b),
        .vert_c     (vert_c),
        .link_a     (link_a),
        .link_b     (link_b),
        .link_c     (link_c),
        .status     (status),
        .count_now  (count_now),
        .out_vert_a (out_vert_a),
        .out_vert_b (out_vert_b),
        .out_vert_c (out_vert_c),
        .out_link_a (out_link_a),
        .out_link_b (out_link_b),
        .out_link_c (out_link_c)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a command is in progress");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == tat_pkg::ST_FULL
        |-> count_now == tat_pkg::CNT_W'(tat_pkg::MAX_TRIANGLES))
        else $error("full status with table not full");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= tat_pkg::ST_RANGE)
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != tat_pkg::ST_DONE
        |-> out_vert_a == '0 && out_link_a == '0)
        else $error("failed command returned row data");

endmodule
